// File: rtl/core/dcf_pkg.sv
// Package for the display command framer: request codes, command bytes,
// queue entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

    // request codes on the input channel
    localparam logic [2:0] REQ_CMD    = 3'd0;
    localparam logic [2:0] REQ_PARAM  = 3'd1;
    localparam logic [2:0] REQ_WINDOW = 3'd2;
    localparam logic [2:0] REQ_PIXEL  = 3'd3;
    localparam logic [2:0] REQ_END    = 3'd4;

    // configuration register indexes
    localparam logic CFG_COL_OFFSET = 1'b0;
    localparam logic CFG_ROW_OFFSET = 1'b1;

    localparam int OFFSET_W = 12;
    localparam int WORD_W   = 16;
    localparam int SUM_W    = WORD_W + 1;

    // controller command bytes
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;
    localparam logic [7:0] PAD_BYTE  = 8'h00;

    // window pair indexes (each pair is pad then byte)
    localparam logic [3:0] WP_CASET  = 4'd0;
    localparam logic [3:0] WP_XS_HI  = 4'd1;
    localparam logic [3:0] WP_XS_LO  = 4'd2;
    localparam logic [3:0] WP_XE_HI  = 4'd3;
    localparam logic [3:0] WP_XE_LO  = 4'd4;
    localparam logic [3:0] WP_RASET  = 4'd5;
    localparam logic [3:0] WP_YS_HI  = 4'd6;
    localparam logic [3:0] WP_YS_LO  = 4'd7;
    localparam logic [3:0] WP_YE_HI  = 4'd8;
    localparam logic [3:0] WP_YE_LO  = 4'd9;
    localparam logic [3:0] WP_RAMWR  = 4'd10;

    localparam int         STEP_W    = 5;
    localparam logic [4:0] WIN_LAST  = 5'd21;

    typedef enum logic [1:0] {
        OP_PADDED,
        OP_PIXEL,
        OP_WINDOW,
        OP_RELEASE
    } t_op;

    // one classified transaction waiting for the back end
    typedef struct packed {
        t_op                op;
        logic               dc;
        logic               rel;
        logic [WORD_W-1:0]  wa;
        logic [WORD_W-1:0]  wb;
        logic [WORD_W-1:0]  wc;
        logic [WORD_W-1:0]  wd;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/core/dcf_in_if.sv
// Input channel of the display command framer: valid/ready plus request fields.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface dcf_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            req_type;
    logic [7:0]            data_byte;
    logic                  final_param;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [15:0]           pixel;

    modport source (
        output valid, req_type, data_byte, final_param,
               x_start, y_start, x_end, y_end, pixel,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, final_param,
               x_start, y_start, x_end, y_end, pixel,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/dcf_out_if.sv
// Output channel of the display command framer: valid/ready plus wire events.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface dcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       byte_valid;
    logic       dc_level;
    logic       select_release;
    logic       last;

    modport source (
        output valid, wire_byte, byte_valid, dc_level, select_release, last,
        input  ready
    );
    modport sink (
        input  valid, wire_byte, byte_valid, dc_level, select_release, last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/display_command_framer_unit.sv
// Display command framer: LCD command, parameter, window and pixel framing
// with 16-bit padding. Depends on dcf_pkg, dcf_in_if, dcf_out_if,
// dcf_front, dcf_queue, dcf_back.
//
// One wire event leaves per cycle while ready is high, from a single output
// byte register that sets the rate. A pixel is sent high then low byte, a
// command or parameter pad then byte, a window as eleven pad/byte pairs, an
// end request as one select-only event; dropped requests send nothing.
// A two-entry queue lets new requests in while earlier ones are sent. The
// user must write offsets via the configuration port while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module display_command_framer_unit
    import dcf_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    dcf_in_if.sink                   i_in,
    dcf_out_if.source                o_out,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [OFFSET_W-1:0] i_cfg_data
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    dcf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_entry    (push_entry),
        .o_push     (push)
    );

    dcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dcf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: rtl/core/dcf_front.sv
// Front end: accepts requests, tracks burst/command state, adds offsets and
// pushes classified entries. Depends on dcf_pkg and dcf_in_if.
`timescale 1ns / 1ps
`default_nettype none

module dcf_front
    import dcf_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    dcf_in_if.sink                   i_in,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [OFFSET_W-1:0] i_cfg_data,
    input  wire logic                i_q_full,
    output t_entry                   o_entry,
    output logic                     o_push
);

    logic                r_burst_open, n_burst_open;
    logic                r_cmd_open,   n_cmd_open;
    logic [OFFSET_W-1:0] r_col_off;
    logic [OFFSET_W-1:0] r_row_off;
    logic                accept;
    logic [SUM_W-1:0]    xs_sum, xe_sum, ys_sum, ye_sum;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    // wrap to 16 bits
    assign xs_sum = SUM_W'(i_in.x_start[COORD_BITS-1:0]) + SUM_W'(r_col_off);
    assign xe_sum = SUM_W'(i_in.x_end[COORD_BITS-1:0])   + SUM_W'(r_col_off);
    assign ys_sum = SUM_W'(i_in.y_start[COORD_BITS-1:0]) + SUM_W'(r_row_off);
    assign ye_sum = SUM_W'(i_in.y_end[COORD_BITS-1:0])   + SUM_W'(r_row_off);

    always_comb begin
        n_burst_open = r_burst_open;
        n_cmd_open   = r_cmd_open;
        o_push       = 1'b0;
        o_entry.op   = OP_PADDED;
        o_entry.dc   = 1'b0;
        o_entry.rel  = i_in.final_param;
        o_entry.wa   = {PAD_BYTE, i_in.data_byte};
        o_entry.wb   = xe_sum[WORD_W-1:0];
        o_entry.wc   = ys_sum[WORD_W-1:0];
        o_entry.wd   = ye_sum[WORD_W-1:0];
        unique case (i_in.req_type)
            REQ_CMD: begin
                o_push       = accept;
                n_burst_open = 1'b0;
                n_cmd_open   = !i_in.final_param;
            end
            REQ_PARAM: begin
                o_entry.dc = 1'b1;
                if (r_cmd_open) begin
                    o_push     = accept;
                    n_cmd_open = !i_in.final_param;
                end
            end
            REQ_WINDOW: begin
                o_entry.op   = OP_WINDOW;
                o_entry.wa   = xs_sum[WORD_W-1:0];
                o_push       = accept;
                n_burst_open = 1'b1;
                n_cmd_open   = 1'b0;
            end
            REQ_PIXEL: begin
                o_entry.op = OP_PIXEL;
                o_entry.dc = 1'b1;
                o_entry.wa = i_in.pixel;
                o_push     = accept && r_burst_open;
            end
            REQ_END: begin
                o_entry.op   = OP_RELEASE;
                o_entry.dc   = 1'b1;
                o_entry.rel  = 1'b1;
                o_push       = accept;
                n_burst_open = 1'b0;
                n_cmd_open   = 1'b0;
            end
            default: begin
                // unused codes: drop
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_open <= 1'b0;
            r_cmd_open   <= 1'b0;
            r_col_off    <= '0;
            r_row_off    <= '0;
        end else begin
            if (accept) begin
                r_burst_open <= n_burst_open;
                r_cmd_open   <= n_cmd_open;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COL_OFFSET: r_col_off <= i_cfg_data;
                    CFG_ROW_OFFSET: r_row_off <= i_cfg_data;
                    default:        r_col_off <= r_col_off;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dcf_queue.sv
// Two-entry queue between front and back end of the framer.
// Depends on dcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcf_queue
    import dcf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_full,
    output logic        o_empty
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dcf_back.sv
// Back end: walks each queued entry byte by byte into the output register.
// Depends on dcf_pkg and dcf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module dcf_back
    import dcf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    dcf_out_if.source   o_out
);

    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_bv;
    logic              r_dc;
    logic              r_rel;
    logic              r_last;
    logic [STEP_W-1:0] r_step;

    logic              advance;
    logic              produce;
    logic [7:0]        n_byte;
    logic              n_bv, n_dc, n_rel, n_last;
    logic [3:0]        pair;
    logic [7:0]        win_byte;
    logic              win_dc;

    assign advance = !r_valid || o_out.ready;
    assign produce = advance && !i_empty;
    assign o_pop   = produce && n_last;
    assign pair    = r_step[STEP_W-1:1];

    // window sequence: byte of each pair and its data/command level
    always_comb begin
        win_dc = 1'b1;
        unique case (pair)
            WP_CASET: begin win_byte = CMD_CASET; win_dc = 1'b0; end
            WP_XS_HI: win_byte = i_head.wa[15:8];
            WP_XS_LO: win_byte = i_head.wa[7:0];
            WP_XE_HI: win_byte = i_head.wb[15:8];
            WP_XE_LO: win_byte = i_head.wb[7:0];
            WP_RASET: begin win_byte = CMD_RASET; win_dc = 1'b0; end
            WP_YS_HI: win_byte = i_head.wc[15:8];
            WP_YS_LO: win_byte = i_head.wc[7:0];
            WP_YE_HI: win_byte = i_head.wd[15:8];
            WP_YE_LO: win_byte = i_head.wd[7:0];
            WP_RAMWR: begin win_byte = CMD_RAMWR; win_dc = 1'b0; end
            default:  win_byte = PAD_BYTE;
        endcase
    end

    always_comb begin
        n_byte = PAD_BYTE;
        n_bv   = 1'b1;
        n_dc   = i_head.dc;
        n_rel  = 1'b0;
        n_last = 1'b0;
        unique case (i_head.op)
            OP_PADDED: begin
                if (r_step[0]) begin
                    n_byte = i_head.wa[7:0];
                    n_rel  = i_head.rel;
                    n_last = 1'b1;
                end
            end
            OP_PIXEL: begin
                n_byte = r_step[0] ? i_head.wa[7:0] : i_head.wa[15:8];
                n_last = r_step[0];
            end
            OP_WINDOW: begin
                n_dc = win_dc;
                if (r_step[0]) begin
                    n_byte = win_byte;
                    n_rel  = (pair == WP_XE_LO) || (pair == WP_YE_LO) ||
                             (pair == WP_RAMWR);
                end
                n_last = (r_step == WIN_LAST);
            end
            OP_RELEASE: begin
                n_bv   = 1'b0;
                n_dc   = 1'b1;
                n_rel  = 1'b1;
                n_last = 1'b1;
            end
            default: n_bv = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (advance) begin
            r_valid <= !i_empty;
            if (produce) begin
                r_step <= n_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_byte <= n_byte;
            r_bv   <= n_bv;
            r_dc   <= n_dc;
            r_rel  <= n_rel;
            r_last <= n_last;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.wire_byte      = r_byte;
    assign o_out.byte_valid     = r_bv;
    assign o_out.dc_level       = r_dc;
    assign o_out.select_release = r_rel;
    assign o_out.last           = r_last;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= WIN_LAST)
        else $error("byte step counter beyond window length");

    a_select_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_bv) |-> (r_rel && r_last && r_dc && r_byte == PAD_BYTE))
        else $error("select-only event without release and last");

    a_pop_resets_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == '0) && r_valid && r_last)
        else $error("entry retired without its last byte");

    a_pad_before_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && !r_step[0] && i_head.op != OP_PIXEL && i_head.op != OP_RELEASE)
        |=> (r_byte == PAD_BYTE) && !r_rel)
        else $error("padding byte missing");
`endif

endmodule

`default_nettype wire
